FILE: src/trs_pkg.sv
// Package for the TRS chain compose block: types, state codes, saturating helpers.
// No dependencies.
`timescale 1ns / 1ps
package trs_pkg;
    localparam int unsigned W = 32;
    localparam logic signed [W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [W-1:0] ONE_Q30 = 32'sh4000_0000;

    typedef logic signed [W-1:0] t_word;
    typedef logic signed [67:0] t_acc;

    typedef struct packed {
        logic  first_link;
        logic  last_link;
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word rot_x;
        t_word rot_y;
        t_word rot_z;
        t_word rot_w;
        t_word scale_x;
        t_word scale_y;
        t_word scale_z;
    } t_in_beat;

    typedef struct packed {
        logic  is_last;
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word rot_x;
        t_word rot_y;
        t_word rot_z;
        t_word rot_w;
        t_word scale_x;
        t_word scale_y;
        t_word scale_z;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // one product term into the shared multiply-accumulate unit
    typedef struct packed {
        logic  clr;
        logic  neg;
        t_word a;
        t_word b;
    } t_mac_cmd;

    function automatic t_word sat_shift(input t_acc acc, input logic [4:0] n);
        t_acc r;
        r = (acc + (t_acc'(1) <<< (n - 5'd1))) >>> n;
        if (r > t_acc'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (r < -t_acc'(64'sh8000_0000)) return 32'sh8000_0000;
        return r[W-1:0];
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[W-1:0];
    endfunction
endpackage

FILE: src/trs_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies.
`timescale 1ns / 1ps
interface trs_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/trs_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on trs_pkg.
`timescale 1ns / 1ps
module trs_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  trs_pkg::t_mac_cmd i_cmd,
    output trs_pkg::t_acc     o_acc
);
    import trs_pkg::*;
    logic signed [63:0] r_prod;
    logic               r_clr;
    logic               r_vld;
    t_acc               r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_en;
        end
        r_prod <= i_cmd.neg ? -(i_cmd.a * i_cmd.b) : i_cmd.a * i_cmd.b;
        r_clr  <= i_cmd.clr;
        if (r_vld) begin
            r_acc <= (r_clr ? t_acc'(0) : r_acc) + t_acc'(r_prod);
        end
    end
    assign o_acc = r_acc;
endmodule

FILE: src/trs_transform_chain_compose_unit.sv
// Top level of the TRS chain compose block: sequencer, state, result register.
// Depends on trs_pkg, trs_stream_if, trs_mac.
//
// Usage: the input channel takes one chain link per beat, root first; the
// output channel returns the updated world transform for every link.
// Each link runs on one shared 32x32 multiplier with accumulator, which takes
// 40 product terms in sequence (3 scale, 6 cross, 12 rotate, 16 quaternion,
// 3 scale) as 16 grouped sums, with a pipeline drain after each group. The
// block takes no new link before the result of the last one has been taken:
// input ready is low while a link is in work or its result waits; when the
// receiver stalls the result holds in the output register.
// Reset sets the world transform to identity and empties the block.
// A first_link beat restarts from identity before the link is applied.
`timescale 1ns / 1ps
module trs_transform_chain_compose_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trs_stream_if.sink   in_ch,
    trs_stream_if.source out_ch
);
    import trs_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_step, n_step;
    logic [1:0]  r_wait, n_wait;
    t_in_beat    r_in;
    t_word       r_p [3];
    t_word       r_q [4];
    t_word       r_s [3];
    t_word       r_v [3];
    t_word       r_t [3];
    t_out_beat   r_out;
    t_mac_cmd    cmd;
    logic        mac_en;
    t_acc        acc;
    t_word       lp [3];
    t_word       ls [3];
    t_word       lq [4];

    assign lp = '{r_in.pos_x, r_in.pos_y, r_in.pos_z};
    assign ls = '{r_in.scale_x, r_in.scale_y, r_in.scale_z};
    assign lq = '{r_in.rot_x, r_in.rot_y, r_in.rot_z, r_in.rot_w};

    trs_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (mac_en),
        .i_cmd  (cmd),
        .o_acc  (acc)
    );

    // Groups (step index): terms issued, then the sum settles, then capture.
    // 0-2 v=lp*s | 3-8 t | 9-20 r | 21-36 quat | 37-39 scale
    // group end steps listed in grp_end()
    function automatic t_mac_cmd term(input logic [5:0] k);
        t_mac_cmd c;
        c = '{clr: 1'b0, neg: 1'b0, a: '0, b: '0};
        case (k)
            6'd0:  c = '{1'b1, 1'b0, lp[0], r_s[0]};
            6'd1:  c = '{1'b1, 1'b0, lp[1], r_s[1]};
            6'd2:  c = '{1'b1, 1'b0, lp[2], r_s[2]};
            6'd3:  c = '{1'b1, 1'b0, r_q[1], r_v[2]};
            6'd4:  c = '{1'b0, 1'b1, r_q[2], r_v[1]};
            6'd5:  c = '{1'b1, 1'b0, r_q[2], r_v[0]};
            6'd6:  c = '{1'b0, 1'b1, r_q[0], r_v[2]};
            6'd7:  c = '{1'b1, 1'b0, r_q[0], r_v[1]};
            6'd8:  c = '{1'b0, 1'b1, r_q[1], r_v[0]};
            6'd9:  c = '{1'b1, 1'b0, r_v[0], ONE_Q30};
            6'd10: c = '{1'b0, 1'b0, r_q[3], r_t[0]};
            6'd11: c = '{1'b0, 1'b0, r_q[1], r_t[2]};
            6'd12: c = '{1'b0, 1'b1, r_q[2], r_t[1]};
            6'd13: c = '{1'b1, 1'b0, r_v[1], ONE_Q30};
            6'd14: c = '{1'b0, 1'b0, r_q[3], r_t[1]};
            6'd15: c = '{1'b0, 1'b0, r_q[2], r_t[0]};
            6'd16: c = '{1'b0, 1'b1, r_q[0], r_t[2]};
            6'd17: c = '{1'b1, 1'b0, r_v[2], ONE_Q30};
            6'd18: c = '{1'b0, 1'b0, r_q[3], r_t[2]};
            6'd19: c = '{1'b0, 1'b0, r_q[0], r_t[1]};
            6'd20: c = '{1'b0, 1'b1, r_q[1], r_t[0]};
            6'd21: c = '{1'b1, 1'b0, r_q[3], lq[0]};
            6'd22: c = '{1'b0, 1'b0, r_q[0], lq[3]};
            6'd23: c = '{1'b0, 1'b0, r_q[1], lq[2]};
            6'd24: c = '{1'b0, 1'b1, r_q[2], lq[1]};
            6'd25: c = '{1'b1, 1'b0, r_q[3], lq[1]};
            6'd26: c = '{1'b0, 1'b1, r_q[0], lq[2]};
            6'd27: c = '{1'b0, 1'b0, r_q[1], lq[3]};
            6'd28: c = '{1'b0, 1'b0, r_q[2], lq[0]};
            6'd29: c = '{1'b1, 1'b0, r_q[3], lq[2]};
            6'd30: c = '{1'b0, 1'b0, r_q[0], lq[1]};
            6'd31: c = '{1'b0, 1'b1, r_q[1], lq[0]};
            6'd32: c = '{1'b0, 1'b0, r_q[2], lq[3]};
            6'd33: c = '{1'b1, 1'b0, r_q[3], lq[3]};
            6'd34: c = '{1'b0, 1'b1, r_q[0], lq[0]};
            6'd35: c = '{1'b0, 1'b1, r_q[1], lq[1]};
            6'd36: c = '{1'b0, 1'b1, r_q[2], lq[2]};
            6'd37: c = '{1'b1, 1'b0, r_s[0], ls[0]};
            6'd38: c = '{1'b1, 1'b0, r_s[1], ls[1]};
            6'd39: c = '{1'b1, 1'b0, r_s[2], ls[2]};
            default: c = '{1'b0, 1'b0, '0, '0};
        endcase
        return c;
    endfunction

    // last term of each group: the sequencer waits for its sum before capture
    function automatic logic grp_end(input logic [5:0] k);
        case (k)
            6'd0, 6'd1, 6'd2, 6'd4, 6'd6, 6'd8, 6'd12, 6'd16, 6'd20,
            6'd24, 6'd28, 6'd32, 6'd36, 6'd37, 6'd38, 6'd39: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    always_comb cmd = term(r_step);
    assign mac_en = (r_state == ST_RUN) && (r_wait == 2'd0);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_wait  = r_wait;
        case (r_state)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                    n_wait  = 2'd0;
                end
            end
            ST_RUN: begin
                if (r_wait == 2'd0) begin
                    if (grp_end(r_step)) begin
                        n_wait = 2'd2;
                    end else begin
                        n_step = r_step + 6'd1;
                    end
                end else if (r_wait == 2'd1) begin
                    n_wait = 2'd0;
                    if (r_step == 6'd39) begin
                        n_state = ST_OUT;
                    end else begin
                        n_step = r_step + 6'd1;
                    end
                end else begin
                    n_wait = r_wait - 2'd1;
                end
            end
            ST_OUT: begin
                if (out_ch.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_wait  <= '0;
            r_p     <= '{'0, '0, '0};
            r_q     <= '{'0, '0, '0, ONE_Q30};
            r_s     <= '{ONE_Q16, ONE_Q16, ONE_Q16};
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_wait  <= n_wait;
            if (in_ch.valid && in_ch.ready) begin
                r_in <= in_ch.data;
                if (in_ch.data.first_link) begin
                    r_p <= '{'0, '0, '0};
                    r_q <= '{'0, '0, '0, ONE_Q30};
                    r_s <= '{ONE_Q16, ONE_Q16, ONE_Q16};
                end
            end
            if (r_state == ST_RUN && r_wait == 2'd1) begin
                case (r_step)
                    6'd0, 6'd1, 6'd2: r_v[r_step[1:0]] <= sat_shift(acc, 5'd16);
                    6'd4:  r_t[0] <= sat_shift(acc, 5'd29);
                    6'd6:  r_t[1] <= sat_shift(acc, 5'd29);
                    6'd8:  r_t[2] <= sat_shift(acc, 5'd29);
                    6'd12: r_p[0] <= sat_add(r_p[0], sat_shift(acc, 5'd30));
                    6'd16: r_p[1] <= sat_add(r_p[1], sat_shift(acc, 5'd30));
                    6'd20: r_p[2] <= sat_add(r_p[2], sat_shift(acc, 5'd30));
                    6'd24: r_v[0] <= sat_shift(acc, 5'd30);
                    6'd28: r_v[1] <= sat_shift(acc, 5'd30);
                    6'd32: r_v[2] <= sat_shift(acc, 5'd30);
                    6'd36: r_q <= '{r_v[0], r_v[1], r_v[2], sat_shift(acc, 5'd30)};
                    6'd37: r_s[0] <= sat_shift(acc, 5'd16);
                    6'd38: r_s[1] <= sat_shift(acc, 5'd16);
                    6'd39: r_s[2] <= sat_shift(acc, 5'd16);
                    default: ;
                endcase
            end
        end
        if (r_state == ST_RUN && n_state == ST_OUT) begin
            r_out <= '{r_in.last_link, r_p[0], r_p[1], r_p[2],
                       r_q[0], r_q[1], r_q[2], r_q[3],
                       r_s[0], r_s[1], sat_shift(acc, 5'd16)};
        end
    end

    assign in_ch.ready  = (r_state == ST_IDLE);
    assign out_ch.valid = (r_state == ST_OUT);
    assign out_ch.data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !in_ch.ready)
        else $error("ready while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_step <= 6'd39)
        else $error("step out of range");
endmodule

FILE: bench/tb_trs_transform_chain_compose_unit.sv
// Testbench for the TRS chain compose block: drives chain links, predicts the
// world transform per link in fixed point and compares every result beat.
// Depends on trs_pkg, trs_stream_if and trs_transform_chain_compose_unit.
`timescale 1ns / 1ps
module tb_trs_transform_chain_compose_unit;
    import trs_pkg::*;

    localparam int unsigned N_RANDOM = 730;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint Q16 = 64'sd65536;

    logic i_clk;
    logic i_rst_n;

    trs_stream_if #(.T(t_in_beat))  link_ch ();
    trs_stream_if #(.T(t_out_beat)) world_ch ();

    trs_transform_chain_compose_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (link_ch.sink),
        .out_ch  (world_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    longint    world_pos[3];
    longint    world_rot[4];
    longint    world_scl[3];
    t_out_beat pending_worlds[$];
    t_out_beat typed_worlds[$];
    bit        typed_flags[$];
    int        failures;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact sum in 128 bits, rounded half up, then saturated
    function automatic longint round_terms(input longint a, input longint b,
                                           input longint c, input longint d,
                                           input int n);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b) + 128'(c) + 128'(d);
        s = (s + (128'sd1 <<< (n - 1))) >>> n;
        if (s > 128'sd2147483647) return 64'sd2147483647;
        if (s < -128'sd2147483648) return -64'sd2147483648;
        return longint'(s);
    endfunction

    function automatic void reset_world();
        for (int i = 0; i < 3; i++) begin
            world_pos[i] = 0;
            world_scl[i] = Q16;
        end
        world_rot = '{0, 0, 0, Q30};
    endfunction

    function automatic t_out_beat compose_link(input t_in_beat b);
        longint lp[3], ls[3], lq[4], v[3], t[3], r[3], nq[4];
        longint qx, qy, qz, qw;
        t_out_beat o;
        if (b.first_link) reset_world();
        lp = '{longint'(b.pos_x), longint'(b.pos_y), longint'(b.pos_z)};
        ls = '{longint'(b.scale_x), longint'(b.scale_y), longint'(b.scale_z)};
        lq = '{longint'(b.rot_x), longint'(b.rot_y), longint'(b.rot_z), longint'(b.rot_w)};
        for (int i = 0; i < 3; i++) v[i] = round_terms(lp[i] * world_scl[i], 0, 0, 0, 16);
        qx = world_rot[0]; qy = world_rot[1]; qz = world_rot[2]; qw = world_rot[3];
        t[0] = round_terms(qy * v[2], -qz * v[1], 0, 0, 29);
        t[1] = round_terms(qz * v[0], -qx * v[2], 0, 0, 29);
        t[2] = round_terms(qx * v[1], -qy * v[0], 0, 0, 29);
        r[0] = round_terms(v[0] * Q30, qw * t[0], qy * t[2], -qz * t[1], 30);
        r[1] = round_terms(v[1] * Q30, qw * t[1], qz * t[0], -qx * t[2], 30);
        r[2] = round_terms(v[2] * Q30, qw * t[2], qx * t[1], -qy * t[0], 30);
        for (int i = 0; i < 3; i++) world_pos[i] = clamp32(world_pos[i] + r[i]);
        nq[0] = round_terms(qw * lq[0], qx * lq[3], qy * lq[2], -qz * lq[1], 30);
        nq[1] = round_terms(qw * lq[1], -qx * lq[2], qy * lq[3], qz * lq[0], 30);
        nq[2] = round_terms(qw * lq[2], qx * lq[1], -qy * lq[0], qz * lq[3], 30);
        nq[3] = round_terms(qw * lq[3], -qx * lq[0], -qy * lq[1], -qz * lq[2], 30);
        world_rot = nq;
        for (int i = 0; i < 3; i++) world_scl[i] = round_terms(world_scl[i] * ls[i], 0, 0, 0, 16);
        o.is_last = b.last_link;
        o.pos_x = t_word'(world_pos[0]);
        o.pos_y = t_word'(world_pos[1]);
        o.pos_z = t_word'(world_pos[2]);
        o.rot_x = t_word'(world_rot[0]);
        o.rot_y = t_word'(world_rot[1]);
        o.rot_z = t_word'(world_rot[2]);
        o.rot_w = t_word'(world_rot[3]);
        o.scale_x = t_word'(world_scl[0]);
        o.scale_y = t_word'(world_scl[1]);
        o.scale_z = t_word'(world_scl[2]);
        return o;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    task automatic check_world(input t_out_beat e, input t_out_beat a);
        check_field("is_last", longint'(e.is_last), longint'(a.is_last));
        check_field("world_pos_x", longint'(e.pos_x), longint'(a.pos_x));
        check_field("world_pos_y", longint'(e.pos_y), longint'(a.pos_y));
        check_field("world_pos_z", longint'(e.pos_z), longint'(a.pos_z));
        check_field("world_rot_x", longint'(e.rot_x), longint'(a.rot_x));
        check_field("world_rot_y", longint'(e.rot_y), longint'(a.rot_y));
        check_field("world_rot_z", longint'(e.rot_z), longint'(a.rot_z));
        check_field("world_rot_w", longint'(e.rot_w), longint'(a.rot_w));
        check_field("world_scale_x", longint'(e.scale_x), longint'(a.scale_x));
        check_field("world_scale_y", longint'(e.scale_y), longint'(a.scale_y));
        check_field("world_scale_z", longint'(e.scale_z), longint'(a.scale_z));
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
            1: return t_word'($urandom);
            default: return t_word'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    function automatic t_word rand_quat();
        if ($urandom_range(0, 9) == 0) return rand_word();
        return t_word'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    function automatic t_in_beat rand_link(input bit first, input bit last);
        t_in_beat b;
        b.first_link = first; b.last_link = last;
        b.pos_x = rand_word(); b.pos_y = rand_word(); b.pos_z = rand_word();
        b.rot_x = rand_quat(); b.rot_y = rand_quat();
        b.rot_z = rand_quat(); b.rot_w = rand_quat();
        b.scale_x = rand_word(); b.scale_y = rand_word(); b.scale_z = rand_word();
        return b;
    endfunction

    // directed rows; has_exp marks rows whose result is typed in
    typedef struct {
        t_in_beat  link;
        bit        has_exp;
        t_out_beat exp_world;
    } t_row;

    t_row directed_rows[$];

    task automatic add_row(input t_in_beat b, input bit has_exp, input t_out_beat e);
        t_row r;
        r.link = b; r.has_exp = has_exp; r.exp_world = e;
        directed_rows = {directed_rows, r};
    endtask

    // hold valid until the beat is taken; drop it only while idling
    task automatic send_link(input t_in_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            link_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        link_ch.valid <= 1'b1;
        link_ch.data  <= b;
        @(posedge i_clk);
        while (!link_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        world_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (link_ch.valid && link_ch.ready) begin
            t_out_beat p;
            t_out_beat te;
            bit        f;
            p = compose_link(link_ch.data);
            pending_worlds = {pending_worlds, p};
            if (typed_flags.size() > 0) begin
                f = typed_flags.pop_front();
                te = typed_worlds.pop_front();
                if (f) check_world(te, p);
            end
        end
        if (world_ch.valid && world_ch.ready) begin
            if (pending_worlds.size() == 0) begin
                $error("result beat with no link pending");
                failures++;
            end else begin
                t_out_beat e;
                t_out_beat a;
                e = pending_worlds.pop_front();
                a = world_ch.data;
                check_world(e, a);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (link_ch.valid && link_ch.ready) || (world_ch.valid && world_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_in_beat  b;
        t_out_beat e;
        t_word     mx;
        t_word     mn;
        int        remaining;
        int        chain_len;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        failures = 0;
        idle_cycles = 0;
        send_idle_pct = 29;
        recv_idle_pct = 70;
        i_rst_n = 1'b0;
        link_ch.valid = 1'b0;
        link_ch.data = '0;
        world_ch.ready = 1'b0;
        reset_world();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity link after reset: zero position, identity rotation and scale
        b = '{1'b0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE_Q30,
              ONE_Q16, ONE_Q16, ONE_Q16};
        e = '{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, ONE_Q30,
              ONE_Q16, ONE_Q16, ONE_Q16};
        add_row(b, 1, e);
        // restart with extreme position and scale: both pass through
        b = '{1'b1, 1'b0, mx, mn, 32'sd1, 32'sd0, 32'sd0, 32'sd0, ONE_Q30, mx, mn, 32'sd0};
        e = '{1'b0, mx, mn, 32'sd1, 32'sd0, 32'sd0, 32'sd0, ONE_Q30, mx, mn, 32'sd0};
        add_row(b, 1, e);
        // saturation on accumulated position and scale
        b = '{1'b0, 1'b0, mx, mx, mn, mn, mx, mn, mx, mx, mx, mx};
        add_row(b, 0, e);
        b = '{1'b0, 1'b1, mn, mn, mx, mx, mn, mx, mn, mn, mn, mn};
        add_row(b, 0, e);
        // continue past the last link without restart
        b = '{1'b0, 1'b0, 32'sh0001_8000, -32'sh0000_4000, 32'sd3, 32'sh2d41_3ccd,
              32'sd0, 32'sd0, 32'sh2d41_3ccd, 32'sh0002_0000, 32'sh0000_8000, ONE_Q16};
        add_row(b, 0, e);
        // well-formed chain with 90 degree turns
        for (int k = 0; k < 4; k++) begin
            b = rand_link(k == 0, k == 3);
            b.rot_x = '0; b.rot_y = '0; b.rot_z = 32'sh2d41_3ccd; b.rot_w = 32'sh2d41_3ccd;
            add_row(b, 0, e);
        end
        // non-unit quaternions and all-ones bits
        b = '{1'b1, 1'b1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
              -32'sd1, -32'sd1, -32'sd1};
        add_row(b, 0, e);
        for (int k = 0; k < 8; k++) add_row(rand_link(k % 3 == 0, k % 3 == 2), 0, e);

        foreach (directed_rows[i]) begin
            typed_flags = {typed_flags, directed_rows[i].has_exp};
            typed_worlds = {typed_worlds, directed_rows[i].exp_world};
            send_link(directed_rows[i].link);
        end
        typed_flags.delete();

        remaining = N_RANDOM;
        while (remaining > 0) begin
            if (remaining < N_RANDOM * 2 / 3 && send_idle_pct == 29) begin
                send_idle_pct = 70; recv_idle_pct = 29;
            end
            if (remaining < N_RANDOM / 3 && send_idle_pct == 70) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_link(rand_link(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1))));
                remaining--;
            end else begin
                chain_len = $urandom_range(1, 6);
                for (int k = 0; k < chain_len && remaining > 0; k++) begin
                    send_link(rand_link(k == 0, k == chain_len - 1));
                    remaining--;
                end
            end
        end
        link_ch.valid <= 1'b0;

        while (pending_worlds.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: filelist.f
src/trs_pkg.sv
src/trs_stream_if.sv
src/trs_mac.sv
src/trs_transform_chain_compose_unit.sv
bench/tb_trs_transform_chain_compose_unit.sv
